// ----- src/sync_length_crc_frame_parser_assert.svh -----
// ============================================================================
// Assertion macros for the sync/length/CRC frame parser
// Shared concurrent assertion forms, each reporting through $error.
// ============================================================================
`ifndef SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH
`define SYNC_LENGTH_CRC_FRAME_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLCFP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLCFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/slcfp_pkg.sv -----
// ============================================================================
// slcfp_pkg
// Types, constants and the CRC-16/XMODEM byte step for the frame parser.
// ============================================================================
`timescale 1ns / 1ps

package slcfp_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int HEADER_BYTES  = 7;
    localparam int PL_ADDR_W     = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int PL_CNT_W      = $clog2(PAYLOAD_DEPTH + 1);
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] AGE_MAX  = 16'hFFFF;

    // Item kinds on the input channel.
    localparam logic [2:0] KIND_BYTE    = 3'd0;
    localparam logic [2:0] KIND_TICK    = 3'd1;
    localparam logic [2:0] KIND_FETCH   = 3'd2;
    localparam logic [2:0] KIND_READ    = 3'd3;
    localparam logic [2:0] KIND_RESTART = 3'd4;

    // Fetch status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_FRAME = 2'd1;
    localparam logic [1:0] STATUS_CRC_BAD  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h55;
    localparam logic [15:0] RST_MIN_LEN     = 16'd9;
    localparam logic [15:0] RST_MAX_LEN     = 16'd265;
    localparam logic [15:0] RST_TIMEOUT     = 16'd5000;

    typedef enum logic [2:0] {
        OP_NONE    = 3'd0,
        OP_BYTE    = 3'd1,
        OP_TICK    = 3'd2,
        OP_FETCH   = 3'd3,
        OP_READ    = 3'd4,
        OP_RESTART = 3'd5
    } t_op;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] min_frame_len;
        logic [15:0] max_frame_len;
        logic [15:0] timeout_ticks;
    } t_cfg;

    // One classified item as it travels through the queue.
    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
        logic       is_sync_first;
        logic       is_sync_second;
    } t_qent;

    // One result, short of the payload byte that comes from the store.
    typedef struct packed {
        logic        frame_ready;
        logic [1:0]  status;
        logic [7:0]  version;
        logic [7:0]  control;
        logic [7:0]  command;
        logic [8:0]  payload_len;
        logic [15:0] received_crc;
        logic        rd_hit;
    } t_res;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ----- src/slcfp_in_if.sv -----
// ============================================================================
// slcfp_in_if
// Input item channel: valid/ready handshake with the item fields.
// ============================================================================
`timescale 1ns / 1ps

interface slcfp_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic [7:0] payload_index;

    modport source (output valid, output kind, output data_byte, output payload_index,
                    input ready);
    modport sink (input valid, input kind, input data_byte, input payload_index,
                  output ready);
endinterface

// ----- src/slcfp_out_if.sv -----
// ============================================================================
// slcfp_out_if
// Result channel: valid/ready handshake with the result fields.
// ============================================================================
`timescale 1ns / 1ps

interface slcfp_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ready;
    logic [1:0]  status;
    logic [7:0]  version;
    logic [7:0]  control;
    logic [7:0]  command;
    logic [8:0]  payload_len;
    logic [15:0] received_crc;
    logic [7:0]  payload_byte;

    modport source (output valid, output frame_ready, output status, output version,
                    output control, output command, output payload_len,
                    output received_crc, output payload_byte, input ready);
    modport sink (input valid, input frame_ready, input status, input version,
                  input control, input command, input payload_len,
                  input received_crc, input payload_byte, output ready);
endinterface

// ----- src/slcfp_queue.sv -----
// ============================================================================
// slcfp_queue
// Short FIFO of classified items between the front and the parser.
// ============================================================================
`timescale 1ns / 1ps

module slcfp_queue
    import slcfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_entry,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_qent o_entry
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qent            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- src/slcfp_front.sv -----
// ============================================================================
// slcfp_front
// Takes input transfers, decodes the item kind and marks sync bytes.
// ============================================================================
`timescale 1ns / 1ps

module slcfp_front
    import slcfp_pkg::*;
(
    slcfp_in_if.sink i_in,
    input  t_cfg     i_cfg,
    input  logic     i_full,
    output logic     o_push,
    output t_qent    o_entry
);

    t_op op;

    always_comb begin
        case (i_in.kind)
            KIND_BYTE:    op = OP_BYTE;
            KIND_TICK:    op = OP_TICK;
            KIND_FETCH:   op = OP_FETCH;
            KIND_READ:    op = OP_READ;
            KIND_RESTART: op = OP_RESTART;
            default:      op = OP_NONE;
        endcase
    end

    // Sync compared here; user must only change registers when idle (unenforced).
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    assign o_entry.op             = op;
    assign o_entry.data_byte      = i_in.data_byte;
    assign o_entry.payload_index  = i_in.payload_index;
    assign o_entry.is_sync_first  = (i_in.data_byte == i_cfg.sync_first);
    assign o_entry.is_sync_second = (i_in.data_byte == i_cfg.sync_second);

endmodule

// ----- src/slcfp_back.sv -----
// ============================================================================
// slcfp_back
// Frame parser state machine, payload store and result register.
// ============================================================================
`timescale 1ns / 1ps
`include "sync_length_crc_frame_parser_assert.svh"

module slcfp_back
    import slcfp_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_q_valid,
    input  t_qent          i_entry,
    output logic           o_pop,
    slcfp_out_if.source    o_out
);

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_SYNC   = 6'b000010,
        PH_HEADER = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_DONE   = 6'b010000,
        PH_ERROR  = 6'b100000
    } t_phase;

    localparam logic [2:0]  HDR_VERSION = 3'd0;
    localparam logic [2:0]  HDR_CONTROL = 3'd1;
    localparam logic [2:0]  HDR_COMMAND = 3'd2;
    localparam logic [2:0]  HDR_LEN_HI  = 3'd3;
    localparam logic [2:0]  HDR_LEN_LO  = 3'd4;
    localparam logic [2:0]  HDR_CRC_HI  = 3'd5;
    localparam logic [2:0]  HDR_LAST    = 3'(HEADER_BYTES - 1);
    localparam logic [16:0] DEPTH_17    = 17'(PAYLOAD_DEPTH);
    localparam logic [PL_CNT_W-1:0] DEPTH_CNT = PL_CNT_W'(PAYLOAD_DEPTH);

    t_phase              r_phase, n_phase;
    logic [2:0]          r_hdr_cnt, n_hdr_cnt;
    logic [PL_CNT_W-1:0] r_pl_cnt, n_pl_cnt;
    logic [7:0]          r_version, n_version;
    logic [7:0]          r_control, n_control;
    logic [7:0]          r_command, n_command;
    logic [15:0]         r_length, n_length;
    logic [15:0]         r_hdr_crc, n_hdr_crc;
    logic [15:0]         r_crc, n_crc;
    logic [15:0]         r_age, n_age;

    logic                r_out_valid;
    t_res                r_res;
    t_res                res;

    logic [7:0]          r_store [PAYLOAD_DEPTH];
    logic [7:0]          r_rd_data;
    logic                wr_en;
    logic [PL_ADDR_W-1:0] wr_addr;
    logic [PL_ADDR_W-1:0] rd_addr;
    logic [31:0]         idx_ext;

    logic                pop;
    logic                timed_out;
    t_phase              eff_phase;
    logic [15:0]         crc_next;
    logic [16:0]         len_diff;
    logic [16:0]         pl_next_17;
    logic                len_bad;

    assign pop   = i_q_valid && (!r_out_valid || o_out.ready);
    assign o_pop = pop;

    // A byte item first restarts a parse that has aged past the timeout.
    assign timed_out = (i_entry.op == OP_BYTE) && (r_phase != PH_IDLE) &&
                       (r_age > i_cfg.timeout_ticks);
    assign eff_phase = timed_out ? PH_IDLE : r_phase;
    assign crc_next  = crc16_step((eff_phase == PH_IDLE) ? 16'h0000 : r_crc,
                                  i_entry.data_byte);

    assign len_diff   = {1'b0, r_length} - {1'b0, i_cfg.min_frame_len};
    assign pl_next_17 = 17'(r_pl_cnt) + 17'd1;
    assign len_bad    = (r_length < i_cfg.min_frame_len) ||
                        (r_length > i_cfg.max_frame_len) || (len_diff > DEPTH_17);

    assign idx_ext = 32'(i_entry.payload_index);
    assign rd_addr = idx_ext[PL_ADDR_W-1:0];
    assign wr_addr = r_pl_cnt[PL_ADDR_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pl_cnt  = r_pl_cnt;
        n_version = r_version;
        n_control = r_control;
        n_command = r_command;
        n_length  = r_length;
        n_hdr_crc = r_hdr_crc;
        n_crc     = r_crc;
        n_age     = r_age;
        res       = '0;
        wr_en     = 1'b0;

        if (pop) begin
            case (i_entry.op)
                OP_BYTE: begin
                    if (timed_out) begin
                        n_phase   = PH_IDLE;
                        n_hdr_cnt = '0;
                        n_pl_cnt  = '0;
                        n_version = '0;
                        n_control = '0;
                        n_command = '0;
                        n_length  = '0;
                        n_hdr_crc = '0;
                        n_crc     = '0;
                        n_age     = '0;
                    end
                    case (eff_phase)
                        PH_IDLE: begin
                            if (i_entry.is_sync_first) begin
                                n_phase   = PH_SYNC;
                                n_hdr_cnt = '0;
                                n_pl_cnt  = '0;
                                n_version = '0;
                                n_control = '0;
                                n_command = '0;
                                n_length  = '0;
                                n_hdr_crc = '0;
                                n_crc     = crc_next;
                                n_age     = '0;
                            end
                        end
                        PH_SYNC: begin
                            if (i_entry.is_sync_second) begin
                                n_crc     = crc_next;
                                n_hdr_cnt = '0;
                                n_phase   = PH_HEADER;
                            end else if (!i_entry.is_sync_first) begin
                                n_phase = PH_IDLE;
                                n_age   = '0;
                            end
                        end
                        PH_HEADER: begin
                            case (r_hdr_cnt)
                                HDR_VERSION: n_version = i_entry.data_byte;
                                HDR_CONTROL: n_control = i_entry.data_byte;
                                HDR_COMMAND: n_command = i_entry.data_byte;
                                HDR_LEN_HI:  n_length  = {i_entry.data_byte, 8'h00};
                                HDR_LEN_LO:  n_length  = {r_length[15:8], i_entry.data_byte};
                                HDR_CRC_HI:  n_hdr_crc = {i_entry.data_byte, 8'h00};
                                default:     n_hdr_crc = {r_hdr_crc[15:8], i_entry.data_byte};
                            endcase
                            if (r_hdr_cnt < HDR_CRC_HI) begin
                                n_crc = crc_next;
                            end
                            if (r_hdr_cnt == HDR_LAST) begin
                                n_hdr_cnt = '0;
                                n_pl_cnt  = '0;
                                if (len_bad) begin
                                    n_phase = PH_ERROR;
                                end else if (r_length == i_cfg.min_frame_len) begin
                                    n_phase = PH_DONE;
                                end else begin
                                    n_phase = PH_DATA;
                                end
                            end else begin
                                n_hdr_cnt = r_hdr_cnt + 3'd1;
                            end
                        end
                        PH_DATA: begin
                            wr_en    = (r_pl_cnt < DEPTH_CNT);
                            n_pl_cnt = r_pl_cnt + 1'b1;
                            n_crc    = crc_next;
                            if (pl_next_17 >= len_diff) begin
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    res.frame_ready = (n_phase == PH_DONE);
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE && r_age != AGE_MAX) begin
                        n_age = r_age + 16'd1;
                    end
                end
                OP_FETCH: begin
                    if (r_phase != PH_DONE) begin
                        res.status = STATUS_NO_FRAME;
                    end else begin
                        res.received_crc = r_hdr_crc;
                        if (r_crc != r_hdr_crc) begin
                            res.status = STATUS_CRC_BAD;
                        end else begin
                            res.status      = STATUS_OK;
                            res.version     = r_version;
                            res.control     = r_control;
                            res.command     = r_command;
                            res.payload_len = len_diff[8:0];
                        end
                        n_phase = PH_IDLE;
                        n_age   = '0;
                    end
                end
                OP_READ: begin
                    res.rd_hit = (idx_ext < 32'(r_pl_cnt)) && (idx_ext < 32'(PAYLOAD_DEPTH));
                end
                OP_RESTART: begin
                    n_phase   = PH_IDLE;
                    n_hdr_cnt = '0;
                    n_pl_cnt  = '0;
                    n_version = '0;
                    n_control = '0;
                    n_command = '0;
                    n_length  = '0;
                    n_hdr_crc = '0;
                    n_crc     = '0;
                    n_age     = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hdr_cnt   <= '0;
            r_pl_cnt    <= '0;
            r_version   <= '0;
            r_control   <= '0;
            r_command   <= '0;
            r_length    <= '0;
            r_hdr_crc   <= '0;
            r_crc       <= '0;
            r_age       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_pl_cnt  <= n_pl_cnt;
            r_version <= n_version;
            r_control <= n_control;
            r_command <= n_command;
            r_length  <= n_length;
            r_hdr_crc <= n_hdr_crc;
            r_crc     <= n_crc;
            r_age     <= n_age;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload and the store; the read data only moves with a new result.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_res     <= res;
            r_rd_data <= r_store[rd_addr];
        end
        if (wr_en) begin
            r_store[wr_addr] <= i_entry.data_byte;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_ready  = r_res.frame_ready;
    assign o_out.status       = r_res.status;
    assign o_out.version      = r_res.version;
    assign o_out.control      = r_res.control;
    assign o_out.command      = r_res.command;
    assign o_out.payload_len  = r_res.payload_len;
    assign o_out.received_crc = r_res.received_crc;
    assign o_out.payload_byte = r_res.rd_hit ? r_rd_data : 8'h00;

    `SLCFP_ASSERT_SAME(a_idle_age_zero, i_clk, i_rst_n, r_phase == PH_IDLE, r_age == '0, "age counter running while idle")
    `SLCFP_ASSERT_SAME(a_hdr_cnt_zero, i_clk, i_rst_n, r_phase != PH_HEADER, r_hdr_cnt == '0, "header count left over outside header phase")
    `SLCFP_ASSERT_SAME(a_pl_cnt_bound, i_clk, i_rst_n, r_phase == PH_DATA, r_pl_cnt < DEPTH_CNT, "payload count at store depth while collecting")
    `SLCFP_ASSERT_NEXT(a_fetch_to_idle, i_clk, i_rst_n, pop && i_entry.op == OP_FETCH && r_phase == PH_DONE, r_phase == PH_IDLE && r_out_valid, "fetch of a done frame did not return to hunting")

endmodule

// ----- src/sync_length_crc_frame_parser.sv -----
// ============================================================================
// sync_length_crc_frame_parser
// Byte-stream deframer with sync hunt, length check and CRC-16/XMODEM.
//
// Items arrive on i_in (valid/ready) and every accepted item gives exactly
// one result transfer on o_out. Kinds: stream byte, millisecond tick, fetch
// frame, read payload byte, restart; other kinds give an all-zero result.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data, one
// register per cycle, and the user must write it only while no item is in
// flight; the block itself does not enforce this. An input item is
// registered first in the classifier queue and then in the result register
// behind the parser, which also holds the registered payload store read.
// Throughput is one item per cycle while o_out takes results, with the
// parser doing one CRC byte update and one store write or read per item.
// When o_out stalls, the result register holds, the parser stops taking
// from the two-entry queue, and i_in.ready drops once that queue is full.
// Synchronous reset returns the parser to hunting with all counters and
// header fields cleared and restores the register defaults; the payload
// store is not cleared, and only bytes of the current frame can be read.
// ============================================================================
`timescale 1ns / 1ps

module sync_length_crc_frame_parser
    import slcfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    slcfp_in_if.sink              i_in,
    slcfp_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers, packed as one struct for the two halves.
    t_cfg  r_cfg;

    // Front-to-queue and queue-to-parser handshake.
    logic  push;
    logic  q_full;
    t_qent push_entry;
    logic  q_valid;
    logic  q_pop;
    t_qent q_entry;

    // Writes to an index past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= RST_SYNC_FIRST;
            r_cfg.sync_second   <= RST_SYNC_SECOND;
            r_cfg.min_frame_len <= RST_MIN_LEN;
            r_cfg.max_frame_len <= RST_MAX_LEN;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_cfg.sync_first    <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second   <= i_cfg_data[7:0];
                CFG_MIN_LEN:     r_cfg.min_frame_len <= i_cfg_data;
                CFG_MAX_LEN:     r_cfg.max_frame_len <= i_cfg_data;
                CFG_TIMEOUT:     r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front decodes the kind and compares the byte against both sync
    // values, so the parser sees ready-made flags.
    slcfp_front u_front (
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // Two entries keep one transfer per cycle flowing when o_out does not stall,
    // while parser and front each see only registered flags from the other side.
    slcfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // The parser owns the frame state, the payload store and the result
    // register that drives o_out.
    slcfp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_entry   (q_entry),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ----- tb/sv/tb_sync_length_crc_frame_parser.sv -----
// ============================================================================
// tb_sync_length_crc_frame_parser
// Self-checking testbench for the sync/length/CRC frame parser.
//
// An initial block fills a queue with stream items: a short directed opening,
// then random traffic made mostly of well-formed frames with random content.
// The rest is broken frames, aged frames and loose items. Between phases the
// parser is drained and its registers are rewritten, the extremes included.
// A clocked driver sends the items with random gaps. At each input transfer
// a shadow deframer predicts the result. A clocked monitor stalls the result
// channel at random and compares every result field by field with the
// oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module tb_sync_length_crc_frame_parser;
    import slcfp_pkg::*;

    // Kinds the parser ignores, and a register index beyond the list.
    localparam logic [2:0]           KIND_IGNORED_FIRST = 3'd5;
    localparam logic [2:0]           KIND_IGNORED_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE          = 3'd5;

    localparam int TRAFFIC_PER_PHASE = 300;
    localparam int CYCLE_LIMIT       = 1000000;
    // Aged-frame and timeout paths are only built when this few ticks suffice.
    localparam int SHORT_TIMEOUT     = 40;

    // Parse phases of the shadow deframer.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SYNC_SEEN,
        PH_HEADER,
        PH_BODY,
        PH_DONE,
        PH_FAULT
    } parse_phase_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic [7:0] payload_index;
    } stream_item_t;

    typedef struct packed {
        logic        frame_ready;
        logic [1:0]  status;
        logic [7:0]  version;
        logic [7:0]  control;
        logic [7:0]  command;
        logic [8:0]  payload_len;
        logic [15:0] received_crc;
        logic [7:0]  payload_byte;
    } frame_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SYNC_FIRST;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    slcfp_in_if  in_ch();
    slcfp_out_if out_ch();

    sync_length_crc_frame_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Items waiting to be sent, and results predicted but not yet seen.
    stream_item_t  pending_items[$];
    frame_result_t due_results[$];

    int          n_errors = 0;
    int          gen_count = 0;
    int unsigned xfer_count = 0;
    int unsigned cycle_count = 0;
    int          send_gap = 0;
    int          hold_off = 0;
    stream_item_t  next_item;
    frame_result_t want;

    // Shadow copy of the registers, updated when a write is issued.
    logic [7:0]  reg_sync_first  = RST_SYNC_FIRST;
    logic [7:0]  reg_sync_second = RST_SYNC_SECOND;
    logic [15:0] reg_min_len     = RST_MIN_LEN;
    logic [15:0] reg_max_len     = RST_MAX_LEN;
    logic [15:0] reg_timeout     = RST_TIMEOUT;

    // Shadow parser state.
    parse_phase_t sh_phase = PH_HUNT;
    int           sh_hdr_cnt = 0;
    int           sh_pl_cnt = 0;
    logic [7:0]   sh_version = '0;
    logic [7:0]   sh_control = '0;
    logic [7:0]   sh_command = '0;
    logic [15:0]  sh_length = '0;
    logic [15:0]  sh_hdr_crc = '0;
    logic [15:0]  sh_run_crc = '0;
    logic [15:0]  sh_age = '0;
    logic [7:0]   sh_store[PAYLOAD_DEPTH];

    // CRC-16/XMODEM, one data bit at a time, MSB first.
    function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_parse();
        sh_phase   = PH_HUNT;
        sh_hdr_cnt = 0;
        sh_pl_cnt  = 0;
        sh_version = '0;
        sh_control = '0;
        sh_command = '0;
        sh_length  = '0;
        sh_hdr_crc = '0;
        sh_run_crc = '0;
        sh_age     = '0;
    endfunction

    function automatic void take_stream_byte(logic [7:0] b);
        int          lv;
        logic [31:0] need;
        case (sh_phase)
            PH_HUNT: begin
                // The timer starts over at the first sync byte.
                if (b == reg_sync_first) begin
                    clear_parse();
                    sh_phase   = PH_SYNC_SEEN;
                    sh_run_crc = crc_feed(16'h0000, b);
                end
            end
            PH_SYNC_SEEN: begin
                // The second sync byte wins when both sync bytes are equal;
                // further first sync bytes keep the hunt alive.
                if (b == reg_sync_second) begin
                    sh_run_crc = crc_feed(sh_run_crc, b);
                    sh_hdr_cnt = 0;
                    sh_phase   = PH_HEADER;
                end else if (b != reg_sync_first) begin
                    sh_phase = PH_HUNT;
                    sh_age   = '0;
                end
            end
            PH_HEADER: begin
                case (sh_hdr_cnt)
                    0:       sh_version = b;
                    1:       sh_control = b;
                    2:       sh_command = b;
                    3:       sh_length  = {b, 8'h00};
                    4:       sh_length[7:0] = b;
                    5:       sh_hdr_crc = {b, 8'h00};
                    default: sh_hdr_crc[7:0] = b;
                endcase
                // The two CRC bytes are not covered by the CRC.
                if (sh_hdr_cnt < 5) begin
                    sh_run_crc = crc_feed(sh_run_crc, b);
                end
                sh_hdr_cnt++;
                if (sh_hdr_cnt >= HEADER_BYTES) begin
                    sh_hdr_cnt = 0;
                    sh_pl_cnt  = 0;
                    lv = int'(sh_length);
                    if (lv < int'(reg_min_len) || lv > int'(reg_max_len) ||
                        lv - int'(reg_min_len) > PAYLOAD_DEPTH) begin
                        sh_phase = PH_FAULT;
                    end else if (lv == int'(reg_min_len)) begin
                        sh_phase = PH_DONE;
                    end else begin
                        sh_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (sh_pl_cnt < PAYLOAD_DEPTH) begin
                    sh_store[sh_pl_cnt] = b;
                end
                sh_pl_cnt++;
                sh_run_crc = crc_feed(sh_run_crc, b);
                // Unsigned 32-bit remainder, as wide as the length arithmetic.
                need = {16'h0000, sh_length} - {16'h0000, reg_min_len};
                if (32'(sh_pl_cnt) >= need) begin
                    sh_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Advances the shadow parser by one item and returns the result it gives.
    function automatic frame_result_t deframe_item(logic [2:0] kind, logic [7:0] b,
                                                   logic [7:0] idx);
        frame_result_t r;
        logic [15:0]   diff;
        r = '0;
        case (kind)
            KIND_BYTE: begin
                // A parse that has aged past the timeout restarts first.
                if (sh_phase != PH_HUNT && sh_age > reg_timeout) begin
                    clear_parse();
                end
                take_stream_byte(b);
                r.frame_ready = (sh_phase == PH_DONE);
            end
            KIND_TICK: begin
                if (sh_phase != PH_HUNT && sh_age != AGE_MAX) begin
                    sh_age++;
                end
            end
            KIND_FETCH: begin
                if (sh_phase != PH_DONE) begin
                    r.status = STATUS_NO_FRAME;
                end else begin
                    r.received_crc = sh_hdr_crc;
                    if (sh_run_crc != sh_hdr_crc) begin
                        r.status = STATUS_CRC_BAD;
                    end else begin
                        diff          = sh_length - reg_min_len;
                        r.status      = STATUS_OK;
                        r.version     = sh_version;
                        r.control     = sh_control;
                        r.command     = sh_command;
                        r.payload_len = diff[8:0];
                    end
                    // The payload stays readable until the next first sync byte or restart.
                    sh_phase = PH_HUNT;
                    sh_age   = '0;
                end
            end
            KIND_READ: begin
                if (int'(idx) < sh_pl_cnt) begin
                    r.payload_byte = sh_store[idx];
                end
            end
            KIND_RESTART: begin
                clear_parse();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Both sides go without gaps for one stretch of every four.
    function automatic bit calm_stretch();
        return ((xfer_count / 160) % 4) == 2;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 2);
        end else if (r < 97) begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic void check_field(string name, logic [15:0] want_v,
                                        logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
            n_errors++;
        end
    endfunction

    // Driver: the item is predicted at the edge where its transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                due_results.push_back(deframe_item(in_ch.kind, in_ch.data_byte,
                                                   in_ch.payload_index));
                xfer_count++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (send_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    next_item = pending_items.pop_front();
                    in_ch.kind          <= next_item.kind;
                    in_ch.data_byte     <= next_item.data_byte;
                    in_ch.payload_index <= next_item.payload_index;
                    in_ch.valid         <= 1'b1;
                    send_gap = calm_stretch() ? 0 : pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer and stalls the result channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            hold_off = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("Result transfer arrived with no prediction pending");
                    n_errors++;
                end else begin
                    want = due_results.pop_front();
                    check_field("frame_ready", 16'(want.frame_ready), 16'(out_ch.frame_ready));
                    check_field("status", 16'(want.status), 16'(out_ch.status));
                    check_field("version", 16'(want.version), 16'(out_ch.version));
                    check_field("control", 16'(want.control), 16'(out_ch.control));
                    check_field("command", 16'(want.command), 16'(out_ch.command));
                    check_field("payload_len", 16'(want.payload_len),
                                16'(out_ch.payload_len));
                    check_field("received_crc", want.received_crc, out_ch.received_crc);
                    check_field("payload_byte", 16'(want.payload_byte),
                                16'(out_ch.payload_byte));
                end
            end
            if (hold_off > 0) begin
                out_ch.ready <= 1'b0;
                hold_off--;
            end else begin
                out_ch.ready <= 1'b1;
                if (!calm_stretch() && $urandom_range(0, 99) < 20) begin
                    hold_off = pick_gap();
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [2:0] kind, input logic [7:0] b,
                            input logic [7:0] idx);
        stream_item_t it;
        it = '{kind, b, idx};
        pending_items.push_back(it);
        if (kind <= KIND_RESTART) begin
            gen_count++;
        end
    endtask

    task automatic add_simple(input logic [2:0] kind);
        add_item(kind, 8'($urandom), 8'($urandom));
    endtask

    // A stream byte, sometimes preceded by ticks, an early fetch or a read.
    task automatic frame_byte(input logic [7:0] b);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            repeat ($urandom_range(1, 2)) add_simple(KIND_TICK);
        end else if (r == 3) begin
            add_simple(KIND_FETCH);
        end else if (r == 4) begin
            add_simple(KIND_READ);
        end
        add_item(KIND_BYTE, b, 8'($urandom));
    endtask

    // A complete frame under the current settings; with bad_len set, the
    // length field leaves the legal window or is random, and no payload follows.
    task automatic queue_frame(input bit bad_len);
        int          plen;
        int          lim;
        int          reps;
        int          r;
        logic [15:0] len;
        logic [15:0] crc;
        logic [7:0]  ver;
        logic [7:0]  ctl;
        logic [7:0]  cmd;
        logic [7:0]  body[$];
        logic [7:0]  b;
        logic [7:0]  idx;

        plen = ($urandom_range(0, 39) == 0) ? PAYLOAD_DEPTH : $urandom_range(0, 12);
        lim  = int'(reg_max_len) - int'(reg_min_len);
        if (lim > PAYLOAD_DEPTH) begin
            lim = PAYLOAD_DEPTH;
        end
        if (lim >= 0 && plen > lim) begin
            plen = lim;
        end
        len = 16'(int'(reg_min_len) + plen);
        if (bad_len) begin
            plen = 0;
            case ($urandom_range(0, 3))
                0:       len = (reg_min_len != 0) ? reg_min_len - 16'd1 : 16'($urandom);
                1:       len = (reg_max_len != 16'hFFFF) ? reg_max_len + 16'd1
                                                         : 16'($urandom);
                2:       len = (int'(reg_min_len) + PAYLOAD_DEPTH < 65535)
                               ? 16'(int'(reg_min_len) + PAYLOAD_DEPTH + 1)
                               : 16'($urandom);
                default: len = 16'($urandom);
            endcase
        end
        ver = 8'($urandom);
        ctl = 8'($urandom);
        cmd = 8'($urandom);

        crc = crc_feed(16'h0000, reg_sync_first);
        crc = crc_feed(crc, reg_sync_second);
        crc = crc_feed(crc, ver);
        crc = crc_feed(crc, ctl);
        crc = crc_feed(crc, cmd);
        crc = crc_feed(crc, len[15:8]);
        crc = crc_feed(crc, len[7:0]);
        for (int k = 0; k < plen; k++) begin
            b = 8'($urandom);
            body.push_back(b);
            crc = crc_feed(crc, b);
        end
        if ($urandom_range(0, 99) < 15) begin
            crc = crc ^ 16'($urandom_range(1, 65535));
        end

        // Repeated first sync bytes would read as the second one when the
        // two are equal, so only one is sent then.
        reps = (reg_sync_first == reg_sync_second) ? 1 : $urandom_range(1, 3);
        repeat (reps) frame_byte(reg_sync_first);
        frame_byte(reg_sync_second);
        frame_byte(ver);
        frame_byte(ctl);
        frame_byte(cmd);
        frame_byte(len[15:8]);
        frame_byte(len[7:0]);
        frame_byte(crc[15:8]);
        frame_byte(crc[7:0]);
        foreach (body[k]) begin
            frame_byte(body[k]);
        end

        r = $urandom_range(0, 99);
        if (bad_len) begin
            add_simple(KIND_FETCH);
            if (reg_timeout <= SHORT_TIMEOUT && r < 50) begin
                repeat (int'(reg_timeout) + 1) add_simple(KIND_TICK);
                add_simple(KIND_BYTE);
            end else begin
                add_simple(KIND_RESTART);
            end
        end else if (r < 85) begin
            add_simple(KIND_FETCH);
            repeat ($urandom_range(0, 3)) begin
                idx = ($urandom_range(0, 3) == 0)
                      ? 8'($urandom)
                      : 8'($urandom_range(0, (plen + 1 > 255) ? 255 : plen + 1));
                add_item(KIND_READ, 8'($urandom), idx);
            end
        end else if (r < 92) begin
            add_simple(KIND_RESTART);
        end
        // Otherwise the frame is left waiting; later bytes are ignored until it times out.
    endtask

    // A frame cut short and aged by ticks around the timeout, then a byte.
    task automatic queue_aged_frame();
        add_item(KIND_BYTE, reg_sync_first, 8'($urandom));
        add_item(KIND_BYTE, reg_sync_second, 8'($urandom));
        repeat ($urandom_range(0, 6)) add_simple(KIND_BYTE);
        repeat (int'(reg_timeout) + $urandom_range(0, 1)) add_simple(KIND_TICK);
        if ($urandom_range(0, 1) == 0) begin
            add_item(KIND_BYTE, reg_sync_first, 8'($urandom));
        end else begin
            add_simple(KIND_BYTE);
        end
        add_simple(KIND_RESTART);
    endtask

    // Loose items of every kind, with stray and broken sync pairs.
    task automatic queue_noise();
        int r;
        repeat ($urandom_range(1, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                add_simple(KIND_BYTE);
            end else if (r < 40) begin
                add_item(KIND_BYTE, reg_sync_first, 8'($urandom));
            end else if (r < 50) begin
                add_simple(KIND_TICK);
            end else if (r < 60) begin
                add_simple(KIND_FETCH);
            end else if (r < 72) begin
                add_simple(KIND_READ);
            end else if (r < 78) begin
                add_simple(KIND_RESTART);
            end else if (r < 86) begin
                add_simple(3'($urandom_range(KIND_IGNORED_FIRST, KIND_IGNORED_LAST)));
            end else begin
                add_item(KIND_BYTE, reg_sync_first, 8'($urandom));
                add_simple(KIND_BYTE);
            end
        end
    endtask

    task automatic run_traffic(input int quota);
        int target;
        int r;
        target = gen_count + quota;
        while (gen_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                queue_frame(1'b0);
            end else if (r < 78) begin
                queue_frame(1'b1);
            end else if (r < 84 && reg_timeout <= SHORT_TIMEOUT) begin
                queue_aged_frame();
            end else begin
                queue_noise();
            end
        end
        // Leave the parser hunting before the registers change.
        add_simple(KIND_RESTART);
    endtask

    // Waits until every item has been sent and every result has come back.
    task automatic settle_block();
        do begin
            @(negedge i_clk);
        end while (pending_items.size() != 0 || in_ch.valid || due_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SYNC_FIRST:  reg_sync_first  = val[7:0];
            CFG_SYNC_SECOND: reg_sync_second = val[7:0];
            CFG_MIN_LEN:     reg_min_len     = val;
            CFG_MAX_LEN:     reg_max_len     = val;
            CFG_TIMEOUT:     reg_timeout     = val;
            default: begin
            end
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic [7:0] s1, input logic [7:0] s2,
                                input logic [15:0] mn, input logic [15:0] mx,
                                input logic [15:0] tmo);
        write_reg(CFG_SYNC_FIRST, 16'(s1));
        write_reg(CFG_SYNC_SECOND, 16'(s2));
        write_reg(CFG_MIN_LEN, mn);
        write_reg(CFG_MAX_LEN, mx);
        write_reg(CFG_TIMEOUT, tmo);
    endtask

    initial begin
        logic [7:0]  head[$];
        logic [7:0]  body[$];
        logic [15:0] crc_acc;
        logic [15:0] mn;

        in_ch.valid         = 1'b0;
        in_ch.kind          = KIND_BYTE;
        in_ch.data_byte     = '0;
        in_ch.payload_index = '0;
        out_ch.ready        = 1'b0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening at the reset settings: fetch and read with nothing
        // stored, a tick while hunting, ignored kinds, then a frame with a
        // repeated first sync byte and extreme header and payload values.
        add_simple(KIND_FETCH);
        add_item(KIND_READ, 8'h00, 8'h00);
        add_simple(KIND_TICK);
        add_simple(KIND_IGNORED_FIRST);
        add_simple(KIND_IGNORED_LAST);
        head = '{RST_SYNC_FIRST, RST_SYNC_SECOND, 8'hFF, 8'h00, 8'h5A, 8'h00, 8'h0C};
        body = '{8'h00, 8'hFF, 8'h7E};
        crc_acc = 16'h0000;
        foreach (head[k]) begin
            crc_acc = crc_feed(crc_acc, head[k]);
        end
        foreach (body[k]) begin
            crc_acc = crc_feed(crc_acc, body[k]);
        end
        add_item(KIND_BYTE, RST_SYNC_FIRST, 8'hFF);
        foreach (head[k]) begin
            add_item(KIND_BYTE, head[k], 8'h00);
        end
        add_item(KIND_BYTE, crc_acc[15:8], 8'h00);
        add_item(KIND_BYTE, crc_acc[7:0], 8'h00);
        foreach (body[k]) begin
            add_item(KIND_BYTE, body[k], 8'hFF);
        end
        add_item(KIND_FETCH, 8'hFF, 8'hFF);
        add_item(KIND_READ, 8'h00, 8'h02);
        add_item(KIND_READ, 8'hFF, 8'h03);
        add_simple(KIND_RESTART);

        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        // Widest window, zero overhead, and a timeout that any tick exceeds.
        apply_config(8'h00, 8'hFF, 16'h0000, 16'hFFFF, 16'h0000);
        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        // Only the largest length is legal, and the timer can never expire.
        apply_config(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        // Equal sync bytes, and a minimum above the maximum: every length fails.
        apply_config(8'h5A, 8'h5A, 16'd20, 16'd10, 16'd7);
        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        mn = 16'($urandom_range(0, 40));
        apply_config(8'($urandom), 8'($urandom), mn, mn + 16'($urandom_range(0, 300)),
                     16'($urandom_range(3, SHORT_TIMEOUT)));
        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        // Back to the usual framing with a short timeout; a write to an index
        // beyond the register list must change nothing.
        apply_config(RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MIN_LEN, RST_MAX_LEN, 16'd20);
        write_reg(CFG_SPARE, 16'($urandom));
        run_traffic(TRAFFIC_PER_PHASE);
        settle_block();

        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- sync_length_crc_frame_parser.f -----
+incdir+src
src/slcfp_pkg.sv
src/slcfp_in_if.sv
src/slcfp_out_if.sv
src/slcfp_queue.sv
src/slcfp_front.sv
src/slcfp_back.sv
src/sync_length_crc_frame_parser.sv
tb/sv/tb_sync_length_crc_frame_parser.sv
